// File: rtl/utf8_ucs2_transcoder_macros.svh
// ----------------------------------------------------------------------------
// utf8_ucs2_transcoder_macros
// Assertion helpers for the transcoder RTL.
// ----------------------------------------------------------------------------
// Each macro expects signals named clock and reset in the calling scope.
`ifndef UTF8_UCS2_TRANSCODER_MACROS_SVH
`define UTF8_UCS2_TRANSCODER_MACROS_SVH

// Same-cycle implication, idle during reset.
`define UCS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, idle during reset.
`define UCS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/ucs_pkg.sv
// ----------------------------------------------------------------------------
// ucs_pkg
// Constants and types shared by the UTF-8 / 16-bit code unit transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ucs_pkg;

   localparam logic [15:0] ONE_BYTE_MAX = 16'h007f;
   localparam logic [15:0] TWO_BYTE_MAX = 16'h07ff;

   localparam logic [7:0] LEAD2_MARK = 8'hc0;
   localparam logic [7:0] LEAD3_MARK = 8'he0;
   localparam logic [7:0] CONT_MARK  = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'he0;
   localparam logic [7:0] LEAD3_MASK = 8'hf0;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   // Number of continuation bytes still awaited while decoding.
   typedef logic [1:0] pending_type;

   // Position of the next byte to send for an encoded unit.
   typedef logic [1:0] slot_type;

endpackage

`default_nettype wire

// File: rtl/utf8_ucs2_transcoder.sv
// ----------------------------------------------------------------------------
// utf8_ucs2_transcoder
// Streams 16-bit code units to UTF-8 bytes, or UTF-8 bytes to code units.
// ----------------------------------------------------------------------------
// Usage:
//   csr_wr_en / csr_wr_data set the direction (0 encode, 1 decode) and clear
//   any partial decode sequence. Write it only while the block is idle.
//   req_valid / req_ready / req_code_in carry one code unit (encode) or one
//   byte in the low 8 bits (decode) per transaction.
//   rsp_valid / rsp_ready / rsp_value_out / rsp_last_of_run carry results;
//   rsp_last_of_run marks the final result caused by one input transaction.
// Order: an accepted item is held in the input register, and its results
//   then pass into the result register, from which they are offered.
// Flow: an encoded unit leaves as one, two or three UTF-8 bytes, each a
//   separate result through the single result register.
//   The next item is taken in the cycle the current one sends its last byte.
// Stall: while rsp_ready is low the result is held; the input register
//   holds an item that has a result to give, and req_ready then stays low.
// Reset: synchronous, active high; clears both registers' valid flags, the
//   direction (encode) and the pending decode sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_ucs2_transcoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [15:0] req_code_in,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [15:0] rsp_value_out,
   output      logic        rsp_last_of_run
);

   logic                   direction_ff;
   ucs_pkg::pending_type   pending_ff, pending_in;
   logic [9:0]             partial_ff, partial_in;

   logic                   stage_valid_ff, stage_valid_in;
   logic [15:0]            stage_code_ff;
   ucs_pkg::slot_type      slot_ff, slot_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [15:0]            rsp_value_ff;
   logic                   rsp_last_ff;

   logic                   out_free;
   logic                   emits;
   logic                   stage_adv;
   logic                   stage_done;
   logic                   req_take;
   ucs_pkg::slot_type      enc_count;
   ucs_pkg::slot_type      enc_last_slot;
   logic [15:0]            enc_value;
   logic                   dec_emit;
   logic [15:0]            dec_value;
   logic [7:0]             dec_byte;
   logic [15:0]            dec_acc;
   logic [15:0]            out_value;
   logic                   out_last;

   // ---------------- encode path ----------------
   always_comb begin
      priority if (stage_code_ff <= ucs_pkg::ONE_BYTE_MAX) begin
         enc_count = 2'd1;
      end else if (stage_code_ff <= ucs_pkg::TWO_BYTE_MAX) begin
         enc_count = 2'd2;
      end else begin
         enc_count = 2'd3;
      end
   end

   assign enc_last_slot = enc_count - 2'd1;

   always_comb begin
      enc_value = 16'h0000;
      unique case (enc_count)
         2'd1: enc_value = stage_code_ff;
         2'd2: begin
            if (slot_ff == 2'd0) begin
               enc_value = {8'h00, ucs_pkg::LEAD2_MARK | {3'b000, stage_code_ff[10:6]}};
            end else begin
               enc_value = {8'h00, ucs_pkg::CONT_MARK | {2'b00, stage_code_ff[5:0]}};
            end
         end
         default: begin
            unique case (slot_ff)
               2'd0: enc_value = {8'h00,
                                  ucs_pkg::LEAD3_MARK | {4'h0, stage_code_ff[15:12]}};
               2'd1: enc_value = {8'h00,
                                  ucs_pkg::CONT_MARK | {2'b00, stage_code_ff[11:6]}};
               default: enc_value = {8'h00,
                                     ucs_pkg::CONT_MARK | {2'b00, stage_code_ff[5:0]}};
            endcase
         end
      endcase
   end

   // ---------------- decode path ----------------
   assign dec_byte = stage_code_ff[7:0];
   assign dec_acc  = {partial_ff, dec_byte[5:0]};

   always_comb begin
      dec_emit   = 1'b0;
      dec_value  = 16'h0000;
      pending_in = pending_ff;
      partial_in = partial_ff;
      if (pending_ff != 2'd0) begin
         // Take any byte as a continuation.
         if (pending_ff == 2'd1) begin
            dec_emit   = 1'b1;
            dec_value  = dec_acc;
            pending_in = 2'd0;
            partial_in = 10'h000;
         end else begin
            partial_in = dec_acc[9:0];
            pending_in = pending_ff - 2'd1;
         end
      end else if (dec_byte < ucs_pkg::CONT_MARK) begin
         dec_emit  = 1'b1;
         dec_value = {8'h00, dec_byte};
      end else if ((dec_byte & ucs_pkg::LEAD2_MASK) == ucs_pkg::LEAD2_MARK) begin
         partial_in = {5'b00000, dec_byte[4:0]};
         pending_in = 2'd1;
      end else if ((dec_byte & ucs_pkg::LEAD3_MASK) == ucs_pkg::LEAD3_MARK) begin
         partial_in = {6'b000000, dec_byte[3:0]};
         pending_in = 2'd2;
      end
      // Drop stray continuations and long leads.
   end

   // ---------------- flow control ----------------
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign emits      = (direction_ff == ucs_pkg::DIR_DECODE) ? dec_emit : 1'b1;
   assign stage_adv  = stage_valid_ff && (out_free || !emits);
   assign stage_done = stage_adv &&
                       ((direction_ff == ucs_pkg::DIR_DECODE) || (slot_ff == enc_last_slot));
   assign req_ready  = !stage_valid_ff || stage_done;
   assign req_take   = req_valid && req_ready;

   assign out_value = (direction_ff == ucs_pkg::DIR_DECODE) ? dec_value : enc_value;
   assign out_last  = (direction_ff == ucs_pkg::DIR_DECODE) || (slot_ff == enc_last_slot);

   always_comb begin
      stage_valid_in = stage_valid_ff;
      slot_in        = slot_ff;
      if (stage_done) begin
         stage_valid_in = 1'b0;
         slot_in        = 2'd0;
      end else if (stage_adv) begin
         slot_in = slot_ff + 2'd1;
      end
      if (req_take) begin
         stage_valid_in = 1'b1;
         slot_in        = 2'd0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = stage_adv && emits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff   <= ucs_pkg::DIR_ENCODE;
         pending_ff     <= 2'd0;
         partial_ff     <= 10'h000;
         stage_valid_ff <= 1'b0;
         slot_ff        <= 2'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         slot_ff        <= slot_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wr_en) begin
            direction_ff <= csr_wr_data;
            pending_ff   <= 2'd0;
            partial_ff   <= 10'h000;
         end else if (stage_adv && (direction_ff == ucs_pkg::DIR_DECODE)) begin
            pending_ff <= pending_in;
            partial_ff <= partial_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_code_ff <= req_code_in;
      end
      if (out_free && stage_adv && emits) begin
         rsp_value_ff <= out_value;
         rsp_last_ff  <= out_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value_out   = rsp_value_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // ---------------- assertions ----------------
`include "utf8_ucs2_transcoder_macros.svh"

   `UCS_ASSERT_IMPL(a_slot_in_range,
      stage_valid_ff && (direction_ff == ucs_pkg::DIR_ENCODE), slot_ff < enc_count,
      "encode slot beyond byte count")
   `UCS_ASSERT_IMPL(a_pending_max, 1'b1, pending_ff != 2'd3,
      "pending continuation count out of range")
   `UCS_ASSERT_IMPL(a_take_frees_stage, req_take && stage_valid_ff, stage_done,
      "input taken while stage still busy")
   `UCS_ASSERT_IMPL(a_decode_last, rsp_valid_ff && (direction_ff == ucs_pkg::DIR_DECODE),
      rsp_last_ff, "decoded unit not marked last")
   `UCS_ASSERT_NEXT(a_stall_holds_stage, stage_valid_ff && emits && !out_free,
      stage_valid_ff && $stable(slot_ff), "stage moved while result stalled")

endmodule

`default_nettype wire
